/* rtl/mse_pkg.sv */
// Package for the mean and standard error unit.
// Shared widths, packing constants and status codes; no dependencies.
package mse_pkg;

   // Default capacity of the sample store
   localparam int MAX_SAMPLES_DEF = 1024;

   // Field widths
   localparam int SAMPLE_W   = 24;
   localparam int SE_W       = 25;
   localparam int STATUS_W   = 2;
   localparam int SQ_W       = 48;  // square of a deviation magnitude
   localparam int REQ_DATA_W = 24;  // sample_value
   localparam int RSP_DATA_W = 56;  // mean_value, std_error, zero fill
   localparam int RSP_FILL_W = RSP_DATA_W - SAMPLE_W - SE_W;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SINGLE  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

endpackage

/* rtl/mse_jobq.sv */
// Two-entry job queue between the sample front end and the statistics engine.
// Generic payload width; no package dependencies.
module mse_jobq #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] din,
   input  logic         pop,
   output logic [W-1:0] dout,
   output logic         empty
);

   logic [W-1:0] slot_ff [2];
   logic         wp_ff, wp_in;
   logic         rp_ff, rp_in;
   logic [1:0]   cnt_ff, cnt_in;

   assign empty = (cnt_ff == 2'd0);
   assign dout  = slot_ff[rp_ff];

   // pointer and fill count update
   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = ~wp_ff;
      end
      if (pop && !empty) begin
         rp_in = ~rp_ff;
      end
      if (push && !(pop && !empty)) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push && pop && !empty) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= din;
      end
   end

endmodule

/* rtl/mse_front.sv */
// Sample front end: accepts samples, writes the store, keeps count and sum.
// Depends on mse_pkg; pushes one job per data set into the job queue.
module mse_front #(
   parameter int MAX_SAMPLES = mse_pkg::MAX_SAMPLES_DEF,
   parameter int CW          = 11,
   parameter int AW          = 10,
   parameter int SW          = 34
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [mse_pkg::REQ_DATA_W-1:0] req_tdata,  // [23:0] sample_value
   input  logic                           req_tlast,  // last_sample
   output logic                           wr_en,
   output logic [AW-1:0]                  wr_addr,
   output logic [mse_pkg::SAMPLE_W-1:0]   wr_data,
   output logic                           job_push,
   output logic [CW-1:0]                  job_count,
   output logic [SW-1:0]                  job_sum,
   output logic                           job_ovf,
   input  logic                           job_done
);

   import mse_pkg::*;

   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SAMPLES);

   logic [CW-1:0] count_ff, count_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic          ovf_ff, ovf_in;
   logic          pend_ff, pend_in;
   logic          accept;
   logic          room;
   logic [SW-1:0] sample_ext;

   // a set is held off the input until the engine has finished the previous one
   assign req_tready = !pend_ff;
   assign accept     = req_tvalid && !pend_ff;
   assign room       = (count_ff < MAX_CNT);
   assign sample_ext = {{(SW-SAMPLE_W){req_tdata[SAMPLE_W-1]}}, req_tdata[SAMPLE_W-1:0]};

   // store write
   assign wr_en   = accept && room;
   assign wr_addr = count_ff[AW-1:0];
   assign wr_data = req_tdata[SAMPLE_W-1:0];

   // job descriptor carries the totals including this transfer
   assign job_push  = accept && req_tlast;
   assign job_count = room ? count_ff + CW'(1) : count_ff;
   assign job_sum   = room ? sum_ff + sample_ext : sum_ff;
   assign job_ovf   = ovf_ff || !room;

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      ovf_in   = ovf_ff;
      pend_in  = pend_ff;
      if (job_done) begin
         pend_in = 1'b0;
      end
      if (accept) begin
         if (req_tlast) begin
            count_in = '0;
            sum_in   = '0;
            ovf_in   = 1'b0;
            pend_in  = 1'b1;
         end else begin
            count_in = job_count;
            sum_in   = job_sum;
            ovf_in   = job_ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         ovf_ff   <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         ovf_ff   <= ovf_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

/* rtl/mse_div.sv */
// Restoring divider, one quotient bit per cycle, unsigned operands.
// No package dependencies; shared by all divisions of the engine.
module mse_div #(
   parameter int DW = 58,
   parameter int VW = 11
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int CNT_W = $clog2(DW);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]    quo_ff, quo_in;
   logic [VW:0]      rem_ff, rem_in;
   logic [VW-1:0]    dvs_ff, dvs_in;
   logic [VW:0]      trial;
   logic             fits;

   assign done     = done_ff;
   assign quotient = quo_ff;

   // one shift-subtract step
   assign trial = {rem_ff[VW-1:0], quo_ff[DW-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DW - 1);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? trial - {1'b0, dvs_ff} : trial;
         quo_in = {quo_ff[DW-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

endmodule

/* rtl/mse_sqrt.sv */
// Floor square root, one result bit (two radicand bits) per cycle.
// No package dependencies.
module mse_sqrt #(
   parameter int W = 58
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [W-1:0]                radicand,
   output logic                        done,
   output logic [(W + (W % 2))/2-1:0]  root
);

   localparam int W2    = W + (W % 2);
   localparam int HALF  = W2 / 2;
   localparam int CNT_W = $clog2(HALF);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W2-1:0]    val_ff, val_in;
   logic [W2-1:0]    root_ff, root_in;
   logic [W2-1:0]    bit_ff, bit_in;
   logic [W2-1:0]    trial;

   assign done  = done_ff;
   assign root  = root_ff[HALF-1:0];
   assign trial = root_ff + bit_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(HALF - 1);
         val_in  = W2'(radicand);
         root_in = '0;
         bit_in  = {2'b01, {(W2-2){1'b0}}};
      end else if (busy_ff) begin
         if (val_ff >= trial) begin
            val_in  = val_ff - trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      val_ff  <= val_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

endmodule

/* rtl/mse_back.sv */
// Statistics engine: sample store, mean, deviation pass, divisions, root.
// Depends on mse_pkg, mse_div and mse_sqrt; drives the result channel.
module mse_back #(
   parameter int MAX_SAMPLES = mse_pkg::MAX_SAMPLES_DEF,
   parameter int CW          = 11,
   parameter int AW          = 10,
   parameter int SW          = 34,
   parameter int SSD_W       = 58
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [AW-1:0]                  wr_addr,
   input  logic [mse_pkg::SAMPLE_W-1:0]   wr_data,
   input  logic                           q_empty,
   output logic                           q_pop,
   input  logic [CW-1:0]                  q_count,
   input  logic [SW-1:0]                  q_sum,
   input  logic                           q_ovf,
   output logic                           job_done,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [mse_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [23:0] mean_value, [48:24] std_error
   output logic [mse_pkg::STATUS_W-1:0]   rsp_tuser   // [1:0] status
);

   import mse_pkg::*;

   localparam int RT_W = (SSD_W + (SSD_W % 2)) / 2;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MEAN = 7'b0000010,
      ST_PASS = 7'b0000100,
      ST_DIV1 = 7'b0001000,
      ST_DIV2 = 7'b0010000,
      ST_SQRT = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   state_type            state_ff, state_in;
   logic [SAMPLE_W-1:0]  mem [MAX_SAMPLES];

   logic [CW-1:0]        n_ff, n_in;
   logic                 neg_ff, neg_in;
   logic                 ovf_ff, ovf_in;
   logic [SAMPLE_W-1:0]  mean_ff, mean_in;
   logic [SE_W-1:0]      se_ff, se_in;
   logic [SSD_W-1:0]     ssd_ff, ssd_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic                 div_go_ff, div_go_in;
   logic [SSD_W-1:0]     div_a_ff, div_a_in;
   logic [CW-1:0]        div_b_ff, div_b_in;
   logic                 sq_go_ff, sq_go_in;
   logic [SSD_W-1:0]     sq_a_ff, sq_a_in;
   logic                 done_ff, done_in;

   // deviation pipeline
   logic                 s1_v_ff, s2_v_ff, s3_v_ff;
   logic [SAMPLE_W-1:0]  rd_ff;
   logic [SAMPLE_W-1:0]  abs_ff;
   logic [SQ_W-1:0]      sqr_ff;
   logic                 issue;
   logic [SAMPLE_W:0]    diff;
   logic [SAMPLE_W:0]    mag;

   // output register
   logic                 out_v_ff, out_v_in;
   logic [SAMPLE_W-1:0]  out_mean_ff;
   logic [SE_W-1:0]      out_se_ff;
   logic [STATUS_W-1:0]  out_status_ff;
   logic                 out_load;
   logic [STATUS_W-1:0]  status;

   logic                 div_done;
   logic [SSD_W-1:0]     div_q;
   logic                 sq_done;
   logic [RT_W-1:0]      sq_root;
   logic [SW-1:0]        sum_mag;
   logic [SAMPLE_W-1:0]  q_low;

   mse_div #(.DW(SSD_W), .VW(CW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go_ff),
      .dividend (div_a_ff),
      .divisor  (div_b_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   mse_sqrt #(.W(SSD_W)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_go_ff),
      .radicand (sq_a_ff),
      .done     (sq_done),
      .root     (sq_root)
   );

   assign job_done   = done_ff;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {{RSP_FILL_W{1'b0}}, out_se_ff, out_mean_ff};
   assign rsp_tuser  = out_status_ff;

   assign sum_mag = q_sum[SW-1] ? SW'(-q_sum) : q_sum;
   assign q_low   = div_q[SAMPLE_W-1:0];
   assign issue   = (state_ff == ST_PASS) && (idx_ff != n_ff);
   assign out_load = (state_ff == ST_OUT) && (!out_v_ff || rsp_tready);
   assign q_pop   = (state_ff == ST_IDLE) && !q_empty;

   // dropped samples outrank the single-sample case
   always_comb begin
      if (ovf_ff) begin
         status = STATUS_DROPPED;
      end else if (n_ff <= CW'(1)) begin
         status = STATUS_SINGLE;
      end else begin
         status = STATUS_OK;
      end
   end

   // sample store: front end writes, deviation pass reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (issue) begin
         rd_ff <= mem[idx_ff[AW-1:0]];
      end
   end

   // deviation magnitude, square, accumulate
   assign diff = $signed({rd_ff[SAMPLE_W-1], rd_ff}) - $signed({mean_ff[SAMPLE_W-1], mean_ff});
   assign mag  = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : diff;

   always_ff @(posedge clock) begin
      abs_ff <= mag[SAMPLE_W-1:0];
      sqr_ff <= abs_ff * abs_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= issue;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      neg_in    = neg_ff;
      ovf_in    = ovf_ff;
      mean_in   = mean_ff;
      se_in     = se_ff;
      ssd_in    = ssd_ff;
      idx_in    = idx_ff;
      div_go_in = 1'b0;
      div_a_in  = div_a_ff;
      div_b_in  = div_b_ff;
      sq_go_in  = 1'b0;
      sq_a_in   = sq_a_ff;
      done_in   = 1'b0;
      if (s3_v_ff) begin
         ssd_in = ssd_ff + {{(SSD_W-SQ_W){1'b0}}, sqr_ff};
      end
      if (issue) begin
         idx_in = idx_ff + CW'(1);
      end
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               n_in      = q_count;
               neg_in    = q_sum[SW-1];
               ovf_in    = q_ovf;
               div_a_in  = {{(SSD_W-SW){1'b0}}, sum_mag};
               div_b_in  = q_count;
               div_go_in = 1'b1;
               state_in  = ST_MEAN;
            end
         end
         ST_MEAN: begin
            if (div_done && !div_go_ff) begin
               mean_in = neg_ff ? SAMPLE_W'(-q_low) : q_low;
               if (n_ff < CW'(2)) begin
                  se_in    = '0;
                  state_in = ST_OUT;
               end else begin
                  idx_in   = '0;
                  ssd_in   = '0;
                  state_in = ST_PASS;
               end
            end
         end
         ST_PASS: begin
            if (!issue && !s1_v_ff && !s2_v_ff && !s3_v_ff) begin
               div_a_in  = ssd_ff;
               div_b_in  = n_ff - CW'(1);
               div_go_in = 1'b1;
               state_in  = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (div_done && !div_go_ff) begin
               div_a_in  = div_q;
               div_b_in  = n_ff;
               div_go_in = 1'b1;
               state_in  = ST_DIV2;
            end
         end
         ST_DIV2: begin
            if (div_done && !div_go_ff) begin
               sq_a_in  = div_q;
               sq_go_in = 1'b1;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sq_done && !sq_go_ff) begin
               se_in    = sq_root[SE_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         div_go_ff <= 1'b0;
         sq_go_ff  <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         div_go_ff <= div_go_in;
         sq_go_ff  <= sq_go_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      neg_ff   <= neg_in;
      ovf_ff   <= ovf_in;
      mean_ff  <= mean_in;
      se_ff    <= se_in;
      ssd_ff   <= ssd_in;
      idx_ff   <= idx_in;
      div_a_ff <= div_a_in;
      div_b_ff <= div_b_in;
      sq_a_ff  <= sq_a_in;
   end

   // result register, held until the transfer completes
   always_comb begin
      out_v_in = out_v_ff;
      if (out_load) begin
         out_v_in = 1'b1;
      end else if (rsp_tready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_mean_ff   <= mean_ff;
         out_se_ff     <= se_ff;
         out_status_ff <= status;
      end
   end

endmodule

/* rtl/mean_and_standard_error_unit.sv */
// Mean and standard error unit, top level.
// Depends on mse_pkg, mse_front, mse_jobq and mse_back.
//
// Usage:
//   req_ channel carries one Q15.8 sample per transfer, tlast on the final
//   sample of a data set. rsp_ channel gives one result per data set: the mean
//   (truncated toward zero), the standard error of the mean (Q.8) and a status
//   in tuser (ok, single sample, samples dropped beyond MAX_SAMPLES).
//   Samples stream in at one per cycle while req_tready is high. After the
//   tlast transfer req_tready stays low while the engine works on the set:
//   the one-pass deviation sweep over the store's single read port, three
//   divisions in a bit-serial divider (one only for a single sample) and the
//   bit-serial square root, SSD_W = 48 + log2(MAX) (58 for 1024 samples) wide.
//   Input reopens after the result is loaded into the output register: the
//   load sets done_ff (job_done), which then clears the front end's pend_ff.
//   A stalled receiver holds the result in the output register; the next set
//   can be loaded meanwhile, and its own result waits for that register.
//   Reset (synchronous, active high) clears counts, sum and all handshake
//   state; the sample store needs no clearing and takes input right away.
module mean_and_standard_error_unit #(
   parameter int MAX_SAMPLES = mse_pkg::MAX_SAMPLES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [mse_pkg::REQ_DATA_W-1:0] req_tdata,  // [23:0] sample_value
   input  logic                           req_tlast,  // last_sample
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [mse_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [23:0] mean_value, [48:24] std_error
   output logic [mse_pkg::STATUS_W-1:0]   rsp_tuser   // [1:0] status
);

   import mse_pkg::*;

   localparam int CW    = $clog2(MAX_SAMPLES + 1);
   localparam int AW    = $clog2(MAX_SAMPLES);
   localparam int SW    = SAMPLE_W + AW;
   localparam int SSD_W = SQ_W + AW;
   localparam int JOB_W = CW + SW + 1;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [SAMPLE_W-1:0] wr_data;
   logic                job_push;
   logic [CW-1:0]       job_count;
   logic [SW-1:0]       job_sum;
   logic                job_ovf;
   logic                job_done;
   logic                q_pop;
   logic                q_empty;
   logic [JOB_W-1:0]    q_dout;

   mse_front #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .CW          (CW),
      .AW          (AW),
      .SW          (SW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .job_push   (job_push),
      .job_count  (job_count),
      .job_sum    (job_sum),
      .job_ovf    (job_ovf),
      .job_done   (job_done)
   );

   mse_jobq #(.W(JOB_W)) u_jobq (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .din   ({job_ovf, job_sum, job_count}),
      .pop   (q_pop),
      .dout  (q_dout),
      .empty (q_empty)
   );

   mse_back #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .CW          (CW),
      .AW          (AW),
      .SW          (SW),
      .SSD_W       (SSD_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .q_count    (q_dout[CW-1:0]),
      .q_sum      (q_dout[CW+SW-1:CW]),
      .q_ovf      (q_dout[JOB_W-1]),
      .job_done   (job_done),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* rtl/mse_checker.sv */
// Port-level checks for the mean and standard error unit, bound to the top.
// Depends on mse_pkg for port widths.
module mse_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           req_tlast,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [mse_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [mse_pkg::STATUS_W-1:0]   rsp_tuser
);

   import mse_pkg::*;

   // no result is pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // end of a data set closes the input until the engine is done
   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("input still open after last sample");

   // input closes only after a final sample transfer
   a_close_cause: assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(req_tvalid && req_tlast))
      else $error("input closed without a final sample");

   // a new result appears while its data set still holds the input
   a_rsp_with_set: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !req_tready)
      else $error("result without a pending data set");

   // stalled result holds steady
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed");

endmodule

bind mean_and_standard_error_unit mse_checker u_mse_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
